/* sv/telemetry_frame_deframer_macros.svh */
// Assertion macros for the telemetry frame deframer.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef TELEMETRY_FRAME_DEFRAMER_MACROS_SVH
`define TELEMETRY_FRAME_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS

// A condition that must hold at every clock edge outside reset.
`define TDF_ASSERT(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);

// An implication checked in the same cycle.
`define TDF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

`else

`define TDF_ASSERT(lbl, clk, rstn, cond, msg)
`define TDF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

/* sv/tdf_pkg.sv */
// Shared constants, types and control structs for the telemetry frame deframer.
// No dependencies; every other RTL file imports this package.
package tdf_pkg;

  localparam int FrameBytes = 34;
  localparam int AddrW      = 6;
  localparam int RingDepth  = 1 << AddrW;
  localparam int CountW     = 6;
  localparam int ByteW      = 8;

  localparam logic [ByteW-1:0] HeaderByte  = 8'h55;
  localparam logic [ByteW-1:0] LengthByte  = 8'd31;
  localparam logic [ByteW-1:0] TrailerByte = 8'hAA;

  // Offsets 0 and 1 are known to hold the header and length when a frame completes.
  localparam int FirstRead  = 2;
  localparam int LastOffset = FrameBytes - 1;
  localparam int SumFirst   = 2;
  localparam int SumLast    = 29;
  localparam int ShiftBytes = FrameBytes - FirstRead;

  localparam logic [CountW-1:0] FrameLen    = CountW'(FrameBytes);
  localparam logic [CountW-1:0] DropTrailer = CountW'(1);
  localparam logic [CountW-1:0] DropSum     = CountW'(31);
  localparam logic [CountW-1:0] DropNumber  = CountW'(33);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DECIDE,
    ST_REPLAY
  } tdf_state_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [ByteW-1:0] wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } tdf_ram_req_t;

  typedef struct packed {
    logic              start;
    logic              data_vld;
    logic [CountW-1:0] offset;
  } tdf_chk_ctl_t;

  typedef struct packed {
    logic trailer_ok;
    logic sum_ok;
    logic number_ok;
  } tdf_verdict_t;

  typedef struct packed {
    logic [15:0] robot_number;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] lap_value;
    logic [7:0]  card_id;
    logic [31:0] proc_idle;
    logic [15:0] drive_speeds;
    logic [7:0]  error_code;
    logic [7:0]  vehicle_status;
    logic [7:0]  status_machine;
    logic [7:0]  power_level;
    logic [7:0]  attribute;
  } tdf_result_t;

endpackage

/* sv/tdf_window_ram.sv */
// Ring memory holding the received bytes of the current frame window.
// One write port, one read port with registered read data; uses tdf_pkg.
module tdf_window_ram (
  input  logic                 clk,
  input  tdf_pkg::tdf_ram_req_t req,
  output logic [tdf_pkg::ByteW-1:0] rdata
);
  import tdf_pkg::*;

  logic [ByteW-1:0] mem [RingDepth];
  logic [ByteW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/tdf_frame_check.sv */
// Frame checker: collects offsets 2 to 33 of a complete frame as they are read
// back, keeps the running checksum and presents the verdict and fields; uses tdf_pkg.
module tdf_frame_check (
  input  logic                        clk,
  input  tdf_pkg::tdf_chk_ctl_t       ctl,
  input  logic [tdf_pkg::ByteW-1:0]   data,
  output tdf_pkg::tdf_verdict_t       verdict,
  output tdf_pkg::tdf_result_t        result
);
  import tdf_pkg::*;

  localparam int ShiftBits = ShiftBytes * ByteW;

  logic [ByteW-1:0]     sum_r, sum_nxt;
  logic [ShiftBits-1:0] bytes_r, bytes_nxt;

  // Bit position of a frame offset inside the collected bytes.
  function automatic int lsb_of(input int offset);
    return ByteW * (offset - FirstRead);
  endfunction

  always_comb begin
    sum_nxt   = sum_r;
    bytes_nxt = bytes_r;
    if (ctl.start) begin
      sum_nxt = '0;
    end else if (ctl.data_vld && (int'(ctl.offset) inside {[SumFirst:SumLast]})) begin
      sum_nxt = sum_r + data;
    end
    // Bytes arrive in offset order, so the oldest ends up in the low byte.
    if (ctl.data_vld) begin
      bytes_nxt = {data, bytes_r[ShiftBits-1:ByteW]};
    end
  end

  always_ff @(posedge clk) begin
    sum_r   <= sum_nxt;
    bytes_r <= bytes_nxt;
  end

  always_comb begin
    result.robot_number   = {bytes_r[lsb_of(32) +: 8], bytes_r[lsb_of(33) +: 8]};
    result.pos_x          = bytes_r[lsb_of(2) +: 32];
    result.pos_y          = bytes_r[lsb_of(6) +: 32];
    result.lap_value      = bytes_r[lsb_of(10) +: 32];
    result.card_id        = bytes_r[lsb_of(14) +: 8];
    result.proc_idle      = bytes_r[lsb_of(18) +: 32];
    result.drive_speeds   = bytes_r[lsb_of(22) +: 16];
    result.error_code     = bytes_r[lsb_of(24) +: 8];
    result.vehicle_status = bytes_r[lsb_of(25) +: 8];
    result.status_machine = bytes_r[lsb_of(26) +: 8];
    result.power_level    = bytes_r[lsb_of(28) +: 8];
    result.attribute      = bytes_r[lsb_of(29) +: 8];

    verdict.trailer_ok = (bytes_r[lsb_of(31) +: 8] == TrailerByte);
    verdict.sum_ok     = (bytes_r[lsb_of(30) +: 8] == sum_r);
    verdict.number_ok  = (result.robot_number != 16'd0);
  end

endmodule

/* sv/tdf_ctrl.sv */
// Sequencer of the deframer: ring pointers, header tracking, check readback
// and rescan after a rejected frame; uses tdf_pkg and the assertion macros.
`include "telemetry_frame_deframer_macros.svh"

module tdf_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [tdf_pkg::ByteW-1:0] in_rx_byte,
  output tdf_pkg::tdf_ram_req_t     ram_req,
  input  logic [tdf_pkg::ByteW-1:0] ram_rdata,
  output tdf_pkg::tdf_chk_ctl_t     chk_ctl,
  input  tdf_pkg::tdf_verdict_t     verdict,
  input  logic                      out_free,
  output logic                      emit
);
  import tdf_pkg::*;

  // Start of the check readback relative to the tail before the last write.
  localparam logic [AddrW-1:0] CheckBack = AddrW'(FrameBytes - FirstRead - 1);

  tdf_state_t        state_r, state_nxt;
  logic [AddrW-1:0]  tail_r, tail_nxt;
  logic [AddrW-1:0]  cursor_r, cursor_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic [CountW-1:0] left_r, left_nxt;
  logic [CountW-1:0] off_r, off_nxt;
  logic [CountW-1:0] rd_off_r;
  logic              rd_vld_r;
  logic [CountW-1:0] drop;

  // The kept bytes always end at the newest byte, so only their number is tracked.
  function automatic logic [CountW-1:0] keep_count(input logic [CountW-1:0] cnt,
                                                   input logic [ByteW-1:0] b);
    logic [CountW-1:0] res;
    case (cnt)
      CountW'(0): res = (b == HeaderByte) ? CountW'(1) : CountW'(0);
      CountW'(1): res = (b == LengthByte) ? CountW'(2) : CountW'(0);
      default:    res = cnt + CountW'(1);
    endcase
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      tail_r   <= '0;
      cursor_r <= '0;
      count_r  <= '0;
      left_r   <= '0;
      off_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      tail_r   <= tail_nxt;
      cursor_r <= cursor_nxt;
      count_r  <= count_nxt;
      left_r   <= left_nxt;
      off_r    <= off_nxt;
      rd_vld_r <= ram_req.re;
    end
  end

  always_ff @(posedge clk) begin
    rd_off_r <= off_r;
  end

  always_comb begin
    state_nxt  = state_r;
    tail_nxt   = tail_r;
    cursor_nxt = cursor_r;
    count_nxt  = count_r;
    left_nxt   = left_r;
    off_nxt    = off_r;
    drop       = DropTrailer;
    ram_req    = '0;
    in_ready   = 1'b0;
    emit       = 1'b0;
    chk_ctl          = '0;
    chk_ctl.data_vld = rd_vld_r && (state_r == ST_CHECK);
    chk_ctl.offset   = rd_off_r;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = tail_r;
          ram_req.wdata = in_rx_byte;
          tail_nxt      = tail_r + AddrW'(1);
          count_nxt     = keep_count(count_r, in_rx_byte);
          if (count_nxt == FrameLen) begin
            state_nxt     = ST_CHECK;
            cursor_nxt    = tail_r - CheckBack;
            off_nxt       = CountW'(FirstRead);
            chk_ctl.start = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        if (off_r != FrameLen) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = cursor_r;
          cursor_nxt    = cursor_r + AddrW'(1);
          off_nxt       = off_r + CountW'(1);
        end
        if (rd_vld_r && (rd_off_r == CountW'(LastOffset))) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (verdict.trailer_ok && verdict.sum_ok && verdict.number_ok) begin
          if (out_free) begin
            emit      = 1'b1;
            count_nxt = '0;
            state_nxt = ST_IDLE;
          end
        end else begin
          if (!verdict.trailer_ok) begin
            drop = DropTrailer;
          end else if (!verdict.sum_ok) begin
            drop = DropSum;
          end else begin
            drop = DropNumber;
          end
          count_nxt  = '0;
          cursor_nxt = tail_r - AddrW'(FrameLen) + AddrW'(drop);
          left_nxt   = FrameLen - drop;
          state_nxt  = ST_REPLAY;
        end
      end
      ST_REPLAY: begin
        // The bytes left after a drop are fed through the header tracking again.
        if (left_r != '0) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = cursor_r;
          cursor_nxt    = cursor_r + AddrW'(1);
          left_nxt      = left_r - CountW'(1);
        end else begin
          state_nxt = ST_IDLE;
        end
        if (rd_vld_r) begin
          count_nxt = keep_count(count_r, ram_rdata);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `TDF_ASSERT(a_count_range, clk, rst_n, count_r <= FrameLen, "window count beyond frame size")
  `TDF_ASSERT_IMP(a_emit_free, clk, rst_n, emit, out_free, "result emitted into a busy output")
  `TDF_ASSERT_IMP(a_replay_short, clk, rst_n, state_r == ST_REPLAY, count_r < FrameLen,
                  "rescan reached a full frame")
  `TDF_ASSERT_IMP(a_decide_drained, clk, rst_n, state_r == ST_DECIDE, !rd_vld_r,
                  "verdict taken with a readback still in flight")

endmodule

/* sv/telemetry_frame_deframer.sv */
// Telemetry frame deframer top level: window ring, sequencer, checker and output register.
// Depends on tdf_pkg, tdf_window_ram, tdf_frame_check and tdf_ctrl.
//
// Bytes are taken one per cycle while a frame is still being gathered; a byte
// that breaks the header or length pattern costs no extra time. The byte that
// completes a 34-byte frame keeps the input closed while offsets 2 to 33 are
// read back from the 64-entry window ring through its single read port and
// checked. If the frame is rejected, the bytes kept after the drop (33, 3 or 1)
// are rescanned from the ring at one byte per cycle. A good frame leaves the
// checker as soon as the output register is free; the output register holds
// one result, so new bytes are taken while it waits to be read. The ring needs
// no clearing after reset.
module telemetry_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_robot_number,
  output logic [31:0] out_pos_x,
  output logic [31:0] out_pos_y,
  output logic [31:0] out_lap_value,
  output logic [7:0]  out_card_id,
  output logic [31:0] out_proc_idle,
  output logic [15:0] out_drive_speeds,
  output logic [7:0]  out_error_code,
  output logic [7:0]  out_vehicle_status,
  output logic [7:0]  out_status_machine,
  output logic [7:0]  out_power_level,
  output logic [7:0]  out_attribute
);
  import tdf_pkg::*;

  tdf_ram_req_t     ram_req;
  logic [ByteW-1:0] ram_rdata;
  tdf_chk_ctl_t     chk_ctl;
  tdf_verdict_t     verdict;
  tdf_result_t      chk_result;
  tdf_result_t      out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;
  logic             emit;

  tdf_window_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  tdf_frame_check u_check (
    .clk     (clk),
    .ctl     (chk_ctl),
    .data    (ram_rdata),
    .verdict (verdict),
    .result  (chk_result)
  );

  tdf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .ram_req    (ram_req),
    .ram_rdata  (ram_rdata),
    .chk_ctl    (chk_ctl),
    .verdict    (verdict),
    .out_free   (out_free),
    .emit       (emit)
  );

  // The output slot can take a new result when empty or emptied this cycle.
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_nxt       = chk_result;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_robot_number   = out_r.robot_number;
  assign out_pos_x          = out_r.pos_x;
  assign out_pos_y          = out_r.pos_y;
  assign out_lap_value      = out_r.lap_value;
  assign out_card_id        = out_r.card_id;
  assign out_proc_idle      = out_r.proc_idle;
  assign out_drive_speeds   = out_r.drive_speeds;
  assign out_error_code     = out_r.error_code;
  assign out_vehicle_status = out_r.vehicle_status;
  assign out_status_machine = out_r.status_machine;
  assign out_power_level    = out_r.power_level;
  assign out_attribute      = out_r.attribute;

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for telemetry_frame_deframer: byte stream driver, result monitor
// and a frame-level predictor of the deframer. Depends on tdf_pkg and the deframer RTL.
`timescale 1ns / 1ps

module tb;
  import tdf_pkg::*;

  localparam int SumAt         = 30;
  localparam int TrailerAt     = 31;
  localparam int NumberAt      = 32;
  localparam int LastAt        = FrameBytes - 1;
  localparam int HoldOffCycles = 600;
  localparam int DrainCycles   = 100;
  localparam int PhaseBytes    = 400;

  typedef logic [7:0] frame_bytes_t [FrameBytes];

  typedef enum {
    FK_GOOD,
    FK_BAD_LENGTH,
    FK_BAD_TRAILER,
    FK_BAD_SUM,
    FK_ZERO_NUMBER
  } frame_kind_t;

  typedef enum {
    FILL_RANDOM,
    FILL_ZEROS,
    FILL_ONES
  } fill_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_robot_number;
  logic [31:0] out_pos_x;
  logic [31:0] out_pos_y;
  logic [31:0] out_lap_value;
  logic [7:0]  out_card_id;
  logic [31:0] out_proc_idle;
  logic [15:0] out_drive_speeds;
  logic [7:0]  out_error_code;
  logic [7:0]  out_vehicle_status;
  logic [7:0]  out_status_machine;
  logic [7:0]  out_power_level;
  logic [7:0]  out_attribute;

  logic [7:0]  pending_bytes [$];
  logic [7:0]  kept_bytes [$];
  tdf_result_t expected_frames [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int error_count = 0;

  telemetry_frame_deframer i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_robot_number   (out_robot_number),
    .out_pos_x          (out_pos_x),
    .out_pos_y          (out_pos_y),
    .out_lap_value      (out_lap_value),
    .out_card_id        (out_card_id),
    .out_proc_idle      (out_proc_idle),
    .out_drive_speeds   (out_drive_speeds),
    .out_error_code     (out_error_code),
    .out_vehicle_status (out_vehicle_status),
    .out_status_machine (out_status_machine),
    .out_power_level    (out_power_level),
    .out_attribute      (out_attribute)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Frame predictor: keeps the unresolved bytes and rescans them after every drop.
  function automatic void deframe_byte(logic [7:0] rx);
    int          head;
    int          avail;
    logic [7:0]  acc;
    logic [15:0] number;
    tdf_result_t res;
    if (kept_bytes.size() >= FrameBytes) void'(kept_bytes.pop_front());
    kept_bytes.push_back(rx);
    head = 0;
    while (head < kept_bytes.size()) begin
      avail = kept_bytes.size() - head;
      if (kept_bytes[head] != HeaderByte) begin
        head += 1;
        continue;
      end
      if (avail < 2) break;
      if (kept_bytes[head + 1] != LengthByte) begin
        head += 2;
        continue;
      end
      if (avail < FrameBytes) break;
      if (kept_bytes[head + TrailerAt] != TrailerByte) begin
        head += 1;
        continue;
      end
      acc = '0;
      for (int i = SumFirst; i <= SumLast; i++) acc += kept_bytes[head + i];
      if (acc != kept_bytes[head + SumAt]) begin
        head += 31;
        continue;
      end
      number = {kept_bytes[head + NumberAt], kept_bytes[head + NumberAt + 1]};
      if (number == '0) begin
        head += 33;
        continue;
      end
      res.robot_number   = number;
      res.pos_x          = {kept_bytes[head + 5], kept_bytes[head + 4],
                            kept_bytes[head + 3], kept_bytes[head + 2]};
      res.pos_y          = {kept_bytes[head + 9], kept_bytes[head + 8],
                            kept_bytes[head + 7], kept_bytes[head + 6]};
      res.lap_value      = {kept_bytes[head + 13], kept_bytes[head + 12],
                            kept_bytes[head + 11], kept_bytes[head + 10]};
      res.card_id        = kept_bytes[head + 14];
      res.proc_idle      = {kept_bytes[head + 21], kept_bytes[head + 20],
                            kept_bytes[head + 19], kept_bytes[head + 18]};
      res.drive_speeds   = {kept_bytes[head + 23], kept_bytes[head + 22]};
      res.error_code     = kept_bytes[head + 24];
      res.vehicle_status = kept_bytes[head + 25];
      res.status_machine = kept_bytes[head + 26];
      res.power_level    = kept_bytes[head + 28];
      res.attribute      = kept_bytes[head + 29];
      expected_frames.push_back(res);
      head += FrameBytes;
      break;
    end
    repeat (head) void'(kept_bytes.pop_front());
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endtask

  // Driver: a byte stays on the bus until its transaction completes.
  always @(posedge clk) begin : driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) deframe_byte(in_rx_byte);
      if (!in_valid || in_ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid   <= 1'b1;
          in_rx_byte <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    tdf_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_frames.size() == 0) begin
          $error("result with robot_number %0h arrived with none expected", out_robot_number);
          error_count++;
        end else begin
          want = expected_frames.pop_front();
          compare_field("robot_number", 32'(want.robot_number), 32'(out_robot_number));
          compare_field("pos_x", want.pos_x, out_pos_x);
          compare_field("pos_y", want.pos_y, out_pos_y);
          compare_field("lap_value", want.lap_value, out_lap_value);
          compare_field("card_id", 32'(want.card_id), 32'(out_card_id));
          compare_field("proc_idle", want.proc_idle, out_proc_idle);
          compare_field("drive_speeds", 32'(want.drive_speeds), 32'(out_drive_speeds));
          compare_field("error_code", 32'(want.error_code), 32'(out_error_code));
          compare_field("vehicle_status", 32'(want.vehicle_status),
                        32'(out_vehicle_status));
          compare_field("status_machine", 32'(want.status_machine),
                        32'(out_status_machine));
          compare_field("power_level", 32'(want.power_level), 32'(out_power_level));
          compare_field("attribute", 32'(want.attribute), 32'(out_attribute));
        end
      end
      // A new hold-off request closes the result channel for a long stretch.
      if (hold_token != hold_seen) begin
        hold_seen <= hold_token;
        hold_left <= HoldOffCycles;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic fill_t random_fill();
    int pick;
    pick = $urandom_range(15);
    if (pick == 0) return FILL_ZEROS;
    if (pick == 1) return FILL_ONES;
    return FILL_RANDOM;
  endfunction

  function automatic logic [15:0] random_number();
    int pick;
    pick = $urandom_range(7);
    if (pick == 0) return 16'h0001;
    if (pick == 1) return 16'hFFFF;
    return 16'($urandom_range(1, 65535));
  endfunction

  function automatic frame_bytes_t make_frame(frame_kind_t kind, fill_t fill,
                                              logic [15:0] number);
    frame_bytes_t f;
    logic [7:0]   acc;
    f[0] = HeaderByte;
    f[1] = LengthByte;
    acc  = '0;
    for (int i = SumFirst; i <= SumLast; i++) begin
      case (fill)
        FILL_ZEROS: f[i] = 8'h00;
        FILL_ONES:  f[i] = 8'hFF;
        default:    f[i] = 8'($urandom);
      endcase
      acc += f[i];
    end
    f[SumAt]        = acc;
    f[TrailerAt]    = TrailerByte;
    f[NumberAt]     = number[15:8];
    f[NumberAt + 1] = number[7:0];
    case (kind)
      FK_BAD_LENGTH:  f[1] = LengthByte ^ 8'($urandom_range(1, 255));
      FK_BAD_TRAILER: f[TrailerAt] = TrailerByte ^ 8'($urandom_range(1, 255));
      FK_BAD_SUM:     f[SumAt] = acc ^ 8'($urandom_range(1, 255));
      FK_ZERO_NUMBER: begin
        f[NumberAt]     = 8'h00;
        f[NumberAt + 1] = 8'h00;
      end
      default: ;
    endcase
    return f;
  endfunction

  function automatic int push_bytes(frame_bytes_t f, int first, int last);
    for (int i = first; i <= last; i++) pending_bytes.push_back(f[i]);
    return last - first + 1;
  endfunction

  // A failed sum leaves the last three bytes for rescan; these carry the start of the next frame.
  function automatic int push_chained_pair();
    frame_bytes_t f;
    f = make_frame(FK_BAD_SUM, random_fill(), random_number());
    f[NumberAt]     = HeaderByte;
    f[NumberAt + 1] = LengthByte;
    return push_bytes(f, 0, LastAt) +
           push_bytes(make_frame(FK_GOOD, random_fill(), random_number()), 2, LastAt);
  endfunction

  task automatic add_traffic(int goal);
    int added;
    int pick;
    added = 0;
    while (added < goal) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        added += push_bytes(make_frame(FK_GOOD, random_fill(), random_number()), 0, LastAt);
      end else if (pick < 57) begin
        added += push_bytes(make_frame(FK_BAD_LENGTH, FILL_RANDOM, random_number()), 0,
                            LastAt);
      end else if (pick < 64) begin
        added += push_bytes(make_frame(FK_BAD_TRAILER, random_fill(), random_number()), 0,
                            LastAt);
      end else if (pick < 70) begin
        added += push_bytes(make_frame(FK_BAD_SUM, random_fill(), random_number()), 0,
                            LastAt);
      end else if (pick < 75) begin
        added += push_chained_pair();
      end else if (pick < 80) begin
        added += push_bytes(make_frame(FK_ZERO_NUMBER, random_fill(), 16'h0000), 0, LastAt);
      end else if (pick < 85) begin
        // A header and length in front of a frame start a second, overlapping frame.
        pending_bytes.push_back(HeaderByte);
        pending_bytes.push_back(LengthByte);
        added += push_bytes(make_frame(FK_GOOD, random_fill(), random_number()), 0, LastAt);
      end else if (pick < 92) begin
        added += push_bytes(make_frame(FK_GOOD, random_fill(), random_number()), 0,
                            $urandom_range(0, LastAt - 1));
      end else begin
        repeat ($urandom_range(1, 8)) begin
          case ($urandom_range(7))
            0, 1:    pending_bytes.push_back(HeaderByte);
            2:       pending_bytes.push_back(LengthByte);
            default: pending_bytes.push_back(8'($urandom));
          endcase
        end
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_frames.size() != 0)
      @(negedge clk);
  endtask

  initial begin : stimulus
    int unused;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 23;
    recv_idle_pct = 56;
    unused = push_bytes(make_frame(FK_GOOD, FILL_ZEROS, 16'h0001), 0, LastAt);
    unused = push_bytes(make_frame(FK_GOOD, FILL_ONES, 16'hFFFF), 0, LastAt);
    unused = push_bytes(make_frame(FK_GOOD, FILL_RANDOM, 16'h8000), 0, LastAt);
    pending_bytes.push_back(HeaderByte);
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(HeaderByte);
    pending_bytes.push_back(8'hFF);
    unused = push_bytes(make_frame(FK_BAD_TRAILER, FILL_RANDOM, 16'h1234), 0, LastAt);
    unused = push_bytes(make_frame(FK_BAD_SUM, FILL_RANDOM, 16'h00FF), 0, LastAt);
    unused = push_bytes(make_frame(FK_ZERO_NUMBER, FILL_RANDOM, 16'h0000), 0, LastAt);
    unused = push_chained_pair();
    pending_bytes.push_back(HeaderByte);
    pending_bytes.push_back(LengthByte);
    unused = push_bytes(make_frame(FK_GOOD, FILL_RANDOM, 16'h0100), 0, LastAt);
    // One byte short: the next header lands at offset 33 and the frame after it is lost.
    unused = push_bytes(make_frame(FK_GOOD, FILL_RANDOM, 16'h4242), 0, LastAt - 1);
    unused = push_bytes(make_frame(FK_GOOD, FILL_RANDOM, 16'h7777), 0, LastAt);
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(HeaderByte);
    unused = push_bytes(make_frame(FK_GOOD, FILL_RANDOM, 16'h0002), 0, LastAt);
    add_traffic(PhaseBytes);
    wait_drained();

    send_idle_pct = 56;
    recv_idle_pct = 23;
    add_traffic(PhaseBytes);
    wait_drained();

    // Back-to-back good frames against a closed result channel fill the block up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (5) unused = push_bytes(make_frame(FK_GOOD, random_fill(), random_number()), 0,
                                   LastAt);
    hold_token = hold_token + 1;
    add_traffic(PhaseBytes);
    wait_drained();

    repeat (DrainCycles) @(negedge clk);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
